>>> hw/rtl/tds_pkg.sv
package tds_pkg;

  localparam int VW    = 24;
  localparam int IDX_W = 6;

  typedef logic signed [VW-1:0] val_t;

  localparam val_t VMAX = 24'sh7FFFFF;
  localparam val_t VMIN = 24'sh800000;
  // magnitude of the most negative value
  localparam logic [VW:0] MAG_MIN = 25'h0800000;

  typedef struct packed {
    val_t re;
    val_t im;
  } cplx_t;

  typedef struct packed {
    cplx_t sub;
    cplx_t diag;
    cplx_t sup;
    cplx_t rhs;
    logic  last;
  } row_t;

  typedef struct packed {
    row_t row;
    logic diag_zero;
  } qent_t;

endpackage

>>> hw/rtl/tds_if.sv
interface tds_row_if import tds_pkg::*;;
  logic valid;
  logic ready;
  val_t sub_re;
  val_t sub_im;
  val_t diag_re;
  val_t diag_im;
  val_t sup_re;
  val_t sup_im;
  val_t rhs_re;
  val_t rhs_im;
  logic row_last;

  modport source (
    output valid, sub_re, sub_im, diag_re, diag_im, sup_re, sup_im, rhs_re, rhs_im, row_last,
    input  ready
  );
  modport sink (
    input  valid, sub_re, sub_im, diag_re, diag_im, sup_re, sup_im, rhs_re, rhs_im, row_last,
    output ready
  );
endinterface

interface tds_sol_if import tds_pkg::*;;
  logic             valid;
  logic             ready;
  val_t             sol_re;
  val_t             sol_im;
  logic [IDX_W-1:0] sol_index;
  logic             sol_last;
  logic             pivot_error;

  modport source (
    output valid, sol_re, sol_im, sol_index, sol_last, pivot_error,
    input  ready
  );
  modport sink (
    input  valid, sol_re, sol_im, sol_index, sol_last, pivot_error,
    output ready
  );
endinterface

>>> hw/rtl/complex_tridiagonal_solver_top.sv
// Channel   Dir  Word                                          Accepted
// row_in    in   sub, diag, sup, rhs (complex Q8.16), row_last valid & ready
// sol_out   out  sol_re, sol_im, sol_index, sol_last, pivot_error valid & ready
//
// A row costs two passes of the one-bit-per-cycle complex divider and two passes of
// the three-stage multiply-subtract; the first row of a system needs one divider pass.
// After the last row, back substitution steps through S_BS_RD, S_BS_CM, S_BS_WAIT for
// each row above the last, and readout through S_OUT_RD, S_OUT_LD for each element, the
// read states covering the registered memory reads. A two-entry row queue keeps taking
// rows while the solver works. Reset is synchronous on rst; the memories need no clearing.
module complex_tridiagonal_solver_top import tds_pkg::*; #(
  parameter int MAX_ROWS  = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  tds_row_if.sink   row_in,
  tds_sol_if.source sol_out
);

  logic  q_valid;
  logic  q_ready;
  qent_t q_data;

  tds_front u_front (
    .clk     (clk),
    .rst     (rst),
    .row_in  (row_in),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_ready (q_ready)
  );

  tds_back #(.MAX_ROWS(MAX_ROWS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_ready (q_ready),
    .sol_out (sol_out)
  );

endmodule

>>> hw/rtl/tds_ram.sv
module tds_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/tds_front.sv
module tds_front import tds_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  tds_row_if.sink      row_in,
  output logic         q_valid,
  output qent_t        q_data,
  input  logic         q_ready
);

  qent_t      slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] fill;
  logic       push;
  logic       pop;
  qent_t      ent;

  assign row_in.ready = (fill != 2'd2);
  assign push         = row_in.valid && row_in.ready;
  assign q_valid      = (fill != 2'd0);
  assign pop          = q_valid && q_ready;
  assign q_data       = slots[rp];

  always_comb begin
    ent.row.sub.re   = row_in.sub_re;
    ent.row.sub.im   = row_in.sub_im;
    ent.row.diag.re  = row_in.diag_re;
    ent.row.diag.im  = row_in.diag_im;
    ent.row.sup.re   = row_in.sup_re;
    ent.row.sup.im   = row_in.sup_im;
    ent.row.rhs.re   = row_in.rhs_re;
    ent.row.rhs.im   = row_in.rhs_im;
    ent.row.last     = row_in.row_last;
    // flag a zero diagonal, the first-row pivot check
    ent.diag_zero    = (row_in.diag_re == '0) && (row_in.diag_im == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        slots[wp] <= ent;
        wp        <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> hw/rtl/tds_cmsub.sv
module tds_cmsub import tds_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  cplx_t x,
  input  cplx_t y,
  input  cplx_t z,
  output logic  done,
  output cplx_t res
);

  localparam int SW = ((VW + FRAC_BITS > 2 * VW + 1) ? VW + FRAC_BITS : 2 * VW + 1) + 1;
  localparam logic signed [SW-1:0] RND_POS = SW'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [SW-1:0] RND_NEG = RND_POS - SW'(1);

  logic                      v1;
  logic                      v2;
  logic signed [2*VW-1:0]    p_rr;
  logic signed [2*VW-1:0]    p_ii;
  logic signed [2*VW-1:0]    p_ri;
  logic signed [2*VW-1:0]    p_ir;
  cplx_t                     xh;
  logic signed [SW-1:0]      sr;
  logic signed [SW-1:0]      si;

  // round half away from zero, then saturate
  function automatic val_t rnd_sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    r = (v + (v[SW-1] ? RND_NEG : RND_POS)) >>> FRAC_BITS;
    if (r > SW'(VMAX)) begin
      return VMAX;
    end
    if (r < SW'(VMIN)) begin
      return VMIN;
    end
    return val_t'(r[VW-1:0]);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      done <= v2;
    end
    p_rr   <= y.re * z.re;
    p_ii   <= y.im * z.im;
    p_ri   <= y.re * z.im;
    p_ir   <= y.im * z.re;
    xh     <= x;
    sr     <= (SW'(xh.re) <<< FRAC_BITS) - (SW'(p_rr) - SW'(p_ii));
    si     <= (SW'(xh.im) <<< FRAC_BITS) - (SW'(p_ri) + SW'(p_ir));
    if (v2) begin
      res.re <= rnd_sat(sr);
      res.im <= rnd_sat(si);
    end
  end

endmodule

>>> hw/rtl/tds_cdiv.sv
module tds_cdiv import tds_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  cplx_t num,
  input  cplx_t den,
  output logic  done,
  output cplx_t quo
);

  localparam int MW   = 2 * VW;
  localparam int QW   = VW + FRAC_BITS;
  localparam int CNTW = $clog2(QW + 1);

  typedef enum logic [2:0] {S_IDLE, S_SUM, S_ABS, S_CHK, S_ITER, S_FIN} state_t;

  state_t                 state;
  logic signed [MW-1:0]   p_a;
  logic signed [MW-1:0]   p_b;
  logic signed [MW-1:0]   p_c;
  logic signed [MW-1:0]   p_d;
  logic signed [MW-1:0]   p_yr2;
  logic signed [MW-1:0]   p_yi2;
  logic signed [MW:0]     nr;
  logic signed [MW:0]     ni;
  logic [MW-1:0]          d;
  logic [MW-1:0]          mr;
  logic [MW-1:0]          mi;
  logic                   negr;
  logic                   negi;
  logic                   satr;
  logic                   sati;
  logic                   dz;
  logic [MW-1:0]          remr;
  logic [MW-1:0]          remi;
  logic [QW-1:0]          nshr;
  logic [QW-1:0]          nshi;
  logic [QW-1:0]          qr;
  logic [QW-1:0]          qi;
  logic [CNTW-1:0]        cnt;
  logic [MW:0]            r2r;
  logic [MW:0]            r2i;
  logic                   ger;
  logic                   gei;

  function automatic val_t fin(input logic [QW-1:0] qa, input logic neg, input logic sat,
                               input logic zero);
    logic [QW-1:0] q;
    q = (qa >> 1) + QW'(qa[0]);
    if (zero) begin
      return '0;
    end
    if (sat) begin
      return neg ? VMIN : VMAX;
    end
    if (neg) begin
      return (q > QW'(MAG_MIN)) ? VMIN : val_t'(~q[VW-1:0] + 1'b1);
    end
    return (q > QW'(VMAX)) ? VMAX : val_t'(q[VW-1:0]);
  endfunction

  assign r2r = {remr, nshr[QW-1]};
  assign r2i = {remi, nshi[QW-1]};
  assign ger = (r2r >= {1'b0, d});
  assign gei = (r2i >= {1'b0, d});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == S_FIN);
      unique case (state)
        S_IDLE: begin
          p_a   <= num.re * den.re;
          p_b   <= num.im * den.im;
          p_c   <= num.im * den.re;
          p_d   <= num.re * den.im;
          p_yr2 <= den.re * den.re;
          p_yi2 <= den.im * den.im;
          if (start) begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          nr    <= (MW+1)'(p_a) + (MW+1)'(p_b);
          ni    <= (MW+1)'(p_c) - (MW+1)'(p_d);
          d     <= unsigned'(p_yr2) + unsigned'(p_yi2);
          state <= S_ABS;
        end
        S_ABS: begin
          negr  <= nr[MW];
          negi  <= ni[MW];
          mr    <= nr[MW] ? MW'(-nr) : nr[MW-1:0];
          mi    <= ni[MW] ? MW'(-ni) : ni[MW-1:0];
          state <= S_CHK;
        end
        S_CHK: begin
          // integer part of 2^23 or more saturates
          satr  <= ((mr >> (VW - 1)) >= d);
          sati  <= ((mi >> (VW - 1)) >= d);
          dz    <= (d == '0);
          remr  <= mr >> (VW - 1);
          remi  <= mi >> (VW - 1);
          nshr  <= {mr[VW-2:0], {(FRAC_BITS + 1){1'b0}}};
          nshi  <= {mi[VW-2:0], {(FRAC_BITS + 1){1'b0}}};
          cnt   <= CNTW'(QW - 1);
          state <= S_ITER;
        end
        S_ITER: begin
          remr <= ger ? MW'(r2r - {1'b0, d}) : r2r[MW-1:0];
          remi <= gei ? MW'(r2i - {1'b0, d}) : r2i[MW-1:0];
          qr   <= {qr[QW-2:0], ger};
          qi   <= {qi[QW-2:0], gei};
          nshr <= nshr << 1;
          nshi <= nshi << 1;
          if (cnt == '0) begin
            state <= S_FIN;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_FIN: begin
          quo.re <= fin(qr, negr, satr, dz);
          quo.im <= fin(qi, negi, sati, dz);
          state  <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/tds_back.sv
module tds_back import tds_pkg::*; #(
  parameter int MAX_ROWS  = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  qent_t     q_data,
  output logic      q_ready,
  tds_sol_if.source sol_out
);

  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = $clog2(MAX_ROWS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV_G, S_CM_P, S_CM_T, S_DIV_SOL, S_END,
    S_BS_RD, S_BS_CM, S_BS_WAIT, S_OUT_RD, S_OUT_LD, S_ERR_OUT
  } state_t;

  state_t           state;
  qent_t            cur;
  cplx_t            piv;
  cplx_t            psup;
  cplx_t            sol_prev;
  logic [CW-1:0]    cnt;
  logic             err;
  logic [AW-1:0]    k;

  logic             o_valid;
  val_t             o_re;
  val_t             o_im;
  logic [IDX_W-1:0] o_idx;
  logic             o_last;
  logic             o_err;
  logic             o_free;
  logic             o_load;

  logic             div_start;
  logic             div_done;
  cplx_t            div_num;
  cplx_t            div_den;
  cplx_t            div_quo;
  logic             cm_start;
  logic             cm_done;
  cplx_t            cm_x;
  cplx_t            cm_y;
  cplx_t            cm_z;
  cplx_t            cm_res;

  logic             gam_we;
  logic             sol_we;
  logic [AW-1:0]    sol_waddr;
  cplx_t            sol_wdata;
  cplx_t            sol_rd;
  cplx_t            gam_rd;
  logic             take;

  assign q_ready = (state == S_IDLE);
  assign o_free  = !o_valid || sol_out.ready;
  assign o_load  = o_free && (state == S_OUT_LD || state == S_ERR_OUT);
  assign take    = !err && (cnt < CW'(MAX_ROWS));

  assign sol_out.valid       = o_valid;
  assign sol_out.sol_re      = o_re;
  assign sol_out.sol_im      = o_im;
  assign sol_out.sol_index   = o_idx;
  assign sol_out.sol_last    = o_last;
  assign sol_out.pivot_error = o_err;

  tds_cdiv #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  tds_cmsub #(.FRAC_BITS(FRAC_BITS)) u_cms (
    .clk   (clk),
    .rst   (rst),
    .start (cm_start),
    .x     (cm_x),
    .y     (cm_y),
    .z     (cm_z),
    .done  (cm_done),
    .res   (cm_res)
  );

  tds_ram #(.WIDTH(2 * VW), .DEPTH(MAX_ROWS)) u_gamma (
    .clk   (clk),
    .we    (gam_we),
    .waddr (cnt[AW-1:0]),
    .wdata (div_quo),
    .raddr (AW'(k + 1'b1)),
    .rdata (gam_rd)
  );

  tds_ram #(.WIDTH(2 * VW), .DEPTH(MAX_ROWS)) u_sol (
    .clk   (clk),
    .we    (sol_we),
    .waddr (sol_waddr),
    .wdata (sol_wdata),
    .raddr (k),
    .rdata (sol_rd)
  );

  always_comb begin
    div_start = 1'b0;
    div_num   = cm_res;
    div_den   = piv;
    cm_start  = 1'b0;
    cm_x      = cur.row.diag;
    cm_y      = cur.row.sub;
    cm_z      = div_quo;
    gam_we    = 1'b0;
    sol_we    = 1'b0;
    sol_waddr = cnt[AW-1:0];
    sol_wdata = div_quo;
    unique case (state)
      S_IDLE: begin
        if (q_valid && take) begin
          if (cnt == '0) begin
            div_start = !q_data.diag_zero;
            div_num   = q_data.row.rhs;
            div_den   = q_data.row.diag;
          end else begin
            div_start = 1'b1;
            div_num   = psup;
            div_den   = piv;
          end
        end
      end
      S_DIV_G: begin
        gam_we   = div_done;
        cm_start = div_done;
      end
      S_CM_P: begin
        cm_start = cm_done && (cm_res != '0);
        cm_x     = cur.row.rhs;
        cm_y     = cur.row.sub;
        cm_z     = sol_prev;
      end
      S_CM_T: begin
        div_start = cm_done;
      end
      S_DIV_SOL: begin
        sol_we = div_done;
      end
      S_BS_CM: begin
        cm_start = 1'b1;
        cm_x     = sol_rd;
        cm_y     = gam_rd;
        cm_z     = sol_prev;
      end
      S_BS_WAIT: begin
        sol_we    = cm_done;
        sol_waddr = k;
        sol_wdata = cm_res;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      o_valid <= 1'b0;
      cnt     <= '0;
      err     <= 1'b0;
      piv     <= '0;
      psup    <= '0;
    end else begin
      if (o_valid && sol_out.ready && !o_load) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_data;
            if (take) begin
              psup <= q_data.row.sup;
              if (cnt == '0) begin
                if (q_data.diag_zero) begin
                  err   <= 1'b1;
                  state <= S_END;
                end else begin
                  piv   <= q_data.row.diag;
                  state <= S_DIV_SOL;
                end
              end else begin
                state <= S_DIV_G;
              end
            end else begin
              state <= S_END;
            end
          end
        end
        S_DIV_G: begin
          if (div_done) begin
            state <= S_CM_P;
          end
        end
        S_CM_P: begin
          if (cm_done) begin
            piv <= cm_res;
            if (cm_res == '0) begin
              err   <= 1'b1;
              state <= S_END;
            end else begin
              state <= S_CM_T;
            end
          end
        end
        S_CM_T: begin
          if (cm_done) begin
            state <= S_DIV_SOL;
          end
        end
        S_DIV_SOL: begin
          if (div_done) begin
            sol_prev <= div_quo;
            cnt      <= cnt + 1'b1;
            state    <= S_END;
          end
        end
        S_END: begin
          if (!cur.row.last) begin
            state <= S_IDLE;
          end else if (err || cnt == '0) begin
            state <= S_ERR_OUT;
          end else if (cnt == CW'(1)) begin
            k     <= '0;
            state <= S_OUT_RD;
          end else begin
            k     <= AW'(cnt - CW'(2));
            state <= S_BS_RD;
          end
        end
        S_BS_RD: begin
          state <= S_BS_CM;
        end
        S_BS_CM: begin
          state <= S_BS_WAIT;
        end
        S_BS_WAIT: begin
          if (cm_done) begin
            // carry the fresh element down as the next step's upper neighbor
            sol_prev <= cm_res;
            if (k == '0) begin
              state <= S_OUT_RD;
            end else begin
              k     <= k - 1'b1;
              state <= S_BS_RD;
            end
          end
        end
        S_OUT_RD: begin
          state <= S_OUT_LD;
        end
        S_OUT_LD: begin
          if (o_free) begin
            o_valid <= 1'b1;
            o_re    <= sol_rd.re;
            o_im    <= sol_rd.im;
            o_idx   <= IDX_W'(k);
            o_err   <= 1'b0;
            if (k == AW'(cnt - CW'(1))) begin
              o_last <= 1'b1;
              cnt    <= '0;
              err    <= 1'b0;
              piv    <= '0;
              psup   <= '0;
              state  <= S_IDLE;
            end else begin
              o_last <= 1'b0;
              k      <= k + 1'b1;
              state  <= S_OUT_RD;
            end
          end
        end
        S_ERR_OUT: begin
          if (o_free) begin
            o_valid <= 1'b1;
            o_re    <= '0;
            o_im    <= '0;
            o_idx   <= '0;
            o_last  <= 1'b1;
            o_err   <= 1'b1;
            cnt     <= '0;
            err     <= 1'b0;
            piv     <= '0;
            psup    <= '0;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
